// ----- hdl/icsa_pkg.sv -----
// ----------------------------------------------------------------------------
// icsa_pkg
// Shared widths, coefficients, constants and the Q2.30 multiply helper.
// ----------------------------------------------------------------------------
package icsa_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INT_FRAC   = 30;
  localparam int X_W        = FRAC_BITS + 2;
  localparam int ANGLE_W    = FRAC_BITS + 3;
  localparam int ANG_EXT_W  = ANGLE_W + 2;
  localparam int SH         = INT_FRAC - FRAC_BITS;
  localparam int Y30_W      = INT_FRAC + 1;
  localparam int ACC_W      = INT_FRAC + 3;
  localparam int ROOT_W     = 2 * INT_FRAC + 2;
  localparam int ROOT_STEPS = INT_FRAC + 1;
  localparam int POLY_TERMS = 8;
  localparam int FINAL_LAT  = 3;
  localparam int PIPE_LAT   = 1 + ROOT_STEPS + FINAL_LAT;

  localparam logic signed [ACC_W-1:0] COEF [POLY_TERMS] = '{
    33'sd1686629690, -33'sd230423709, 33'sd95540460, -33'sd53874249,
    33'sd33169905, -33'sd18348235, 33'sd7161955, -33'sd1355589
  };

  localparam longint PI_Q30   = 64'sd3373259423;
  localparam longint HALF_Q30 = 64'sd1686629713;
  localparam longint PI_L     = (PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam longint HALF_L   = (HALF_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [ANG_EXT_W-1:0] PI_A   = ANG_EXT_W'(PI_L);
  localparam logic signed [ANG_EXT_W-1:0] HALF_A = ANG_EXT_W'(HALF_L);

  typedef enum logic {
    ACT_ACOS = 1'b0,
    ACT_ASIN = 1'b1
  } icsa_act_t;

  typedef struct packed {
    logic      valid;
    icsa_act_t action;
    logic      neg;
    logic      oor;
  } icsa_sb_t;

  // q2.30 product, magnitude rounded half away from zero
  function automatic logic signed [ACC_W-1:0] mul_q30(
    input logic signed [ACC_W-1:0] a,
    input logic [Y30_W-1:0] b
  );
    logic [ACC_W-1:0] m;
    logic [ACC_W+Y30_W-1:0] p;
    logic [ACC_W-1:0] q;
    m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    p = (ACC_W+Y30_W)'(m) * (ACC_W+Y30_W)'(b);
    p = p + ((ACC_W+Y30_W)'(1) << (INT_FRAC - 1));
    q = ACC_W'(p >> INT_FRAC);
    return a[ACC_W-1] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ----- hdl/icsa_horner.sv -----
// ----------------------------------------------------------------------------
// icsa_horner
// Polynomial in y by Horner's rule, one multiply-add per stage, then a
// delay line that lines the sum up with the square root pipeline.
// ----------------------------------------------------------------------------
module icsa_horner (
  input  logic                                 clk,
  input  logic [icsa_pkg::Y30_W-1:0]           y30_in,
  output logic signed [icsa_pkg::ACC_W-1:0]    acc_out
);
  import icsa_pkg::*;

  localparam int HSTEPS = POLY_TERMS - 1;

  logic signed [ACC_W-1:0] acc_r [ROOT_STEPS];
  logic [Y30_W-1:0]        y30_r [HSTEPS];

  always_ff @(posedge clk) begin
    acc_r[0] <= mul_q30(COEF[POLY_TERMS-1], y30_in) + COEF[POLY_TERMS-2];
    y30_r[0] <= y30_in;
  end

  for (genvar j = 1; j < HSTEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      acc_r[j] <= mul_q30(acc_r[j-1], y30_r[j-1]) + COEF[HSTEPS-1-j];
      y30_r[j] <= y30_r[j-1];
    end
  end

  for (genvar j = HSTEPS; j < ROOT_STEPS; j++) begin : g_dly
    always_ff @(posedge clk) begin
      acc_r[j] <= acc_r[j-1];
    end
  end

  assign acc_out = acc_r[ROOT_STEPS-1];
endmodule

// ----- hdl/icsa_root.sv -----
// ----------------------------------------------------------------------------
// icsa_root
// Bit-by-bit integer square root, one result bit per stage, carrying the
// beat's valid bit and side information.
// ----------------------------------------------------------------------------
module icsa_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icsa_pkg::icsa_sb_t            sb_in,
  input  logic [icsa_pkg::ROOT_W-1:0]   n_in,
  output icsa_pkg::icsa_sb_t            sb_out,
  output logic [icsa_pkg::Y30_W-1:0]    root_out
);
  import icsa_pkg::*;

  icsa_sb_t          sb_r  [ROOT_STEPS];
  logic [ROOT_W-1:0] n_r   [ROOT_STEPS];
  logic [ROOT_W-1:0] res_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    icsa_sb_t          sb_prev;
    logic [ROOT_W-1:0] n_prev, res_prev, sum, n_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign sb_prev  = sb_in;
      assign n_prev   = n_in;
      assign res_prev = '0;
    end else begin : g_rest
      assign sb_prev  = sb_r[k-1];
      assign n_prev   = n_r[k-1];
      assign res_prev = res_r[k-1];
    end

    always_comb begin
      sum = res_prev + BIT;
      if (n_prev >= sum) begin
        n_nxt   = n_prev - sum;
        res_nxt = (res_prev >> 1) + BIT;
      end else begin
        n_nxt   = n_prev;
        res_nxt = res_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[k].valid <= 1'b0;
      end else begin
        sb_r[k].valid <= sb_prev.valid;
      end
      sb_r[k].action <= sb_prev.action;
      sb_r[k].neg    <= sb_prev.neg;
      sb_r[k].oor    <= sb_prev.oor;
      n_r[k]         <= n_nxt;
      res_r[k]       <= res_nxt;
    end
  end

  assign sb_out   = sb_r[ROOT_STEPS-1];
  assign root_out = res_r[ROOT_STEPS-1][Y30_W-1:0];
endmodule

// ----- hdl/icsa_final.sv -----
// ----------------------------------------------------------------------------
// icsa_final
// Product of polynomial and root, rounding to the output format and
// quadrant / operation selection.
// ----------------------------------------------------------------------------
module icsa_final (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  icsa_pkg::icsa_sb_t                    sb_in,
  input  logic signed [icsa_pkg::ACC_W-1:0]     acc_in,
  input  logic [icsa_pkg::Y30_W-1:0]            root_in,
  output logic                                  valid_out,
  output logic [icsa_pkg::ANGLE_W-1:0]          angle_out,
  output logic                                  oor_out
);
  import icsa_pkg::*;

  function automatic logic signed [ANG_EXT_W-1:0] drop_round(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] q;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    q = (m + (ACC_W'(1) << (SH - 1))) >> SH;
    return v[ACC_W-1] ? -$signed(ANG_EXT_W'(q)) : $signed(ANG_EXT_W'(q));
  endfunction

  icsa_sb_t                   sba_r, sbb_r;
  logic signed [ACC_W-1:0]    prod_r;
  logic signed [ANG_EXT_W-1:0] q_r, res_nxt;
  logic                       valid_r, oor_r;
  logic [ANGLE_W-1:0]         angle_r;

  always_comb begin
    if (sbb_r.oor) begin
      res_nxt = (sbb_r.action == ACT_ASIN) ? HALF_A : '0;
    end else if (sbb_r.action == ACT_ACOS) begin
      res_nxt = sbb_r.neg ? PI_A - q_r : q_r;
    end else begin
      res_nxt = sbb_r.neg ? q_r - HALF_A : HALF_A - q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sba_r.valid <= 1'b0;
      sbb_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      sba_r.valid <= sb_in.valid;
      sbb_r.valid <= sba_r.valid;
      valid_r     <= sbb_r.valid;
    end
    sba_r.action <= sb_in.action;
    sba_r.neg    <= sb_in.neg;
    sba_r.oor    <= sb_in.oor;
    sbb_r.action <= sba_r.action;
    sbb_r.neg    <= sba_r.neg;
    sbb_r.oor    <= sba_r.oor;
    prod_r       <= mul_q30(acc_in, root_in);
    q_r          <= drop_round(prod_r);
    angle_r      <= res_nxt[ANGLE_W-1:0];
    oor_r        <= sbb_r.oor;
  end

  assign valid_out = valid_r;
  assign angle_out = angle_r;
  assign oor_out   = oor_r;
endmodule

// ----- hdl/inverse_cosine_sine_approx.sv -----
// ----------------------------------------------------------------------------
// inverse_cosine_sine_approx
// Pipeline: input register, 31 square root stages, 3 product / select
// stages; out_valid marks the beat as it leaves the last of them.
// Throughput: one beat per cycle; busy is always low.
// Reset (synchronous, rst_n low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module inverse_cosine_sine_approx (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic signed [icsa_pkg::X_W-1:0] in_x_value,
  output logic                           out_valid,
  output logic signed [icsa_pkg::ANGLE_W-1:0] out_angle,
  output logic                           out_out_of_range
);
  import icsa_pkg::*;

  logic [X_W-1:0]    y;
  logic [Y30_W-1:0]  y30, rem30;
  icsa_sb_t          sb_nxt, sb_r, sb_root;
  logic [Y30_W-1:0]  y30_r, root;
  logic [ROOT_W-1:0] n_r;
  logic signed [ACC_W-1:0] acc;
  logic [ANGLE_W-1:0] angle;

  always_comb begin
    y             = in_x_value[X_W-1] ? X_W'(-in_x_value) : X_W'(in_x_value);
    sb_nxt.valid  = start;
    sb_nxt.action = icsa_act_t'(in_action);
    sb_nxt.neg    = in_x_value[X_W-1];
    sb_nxt.oor    = y > (X_W'(1) << FRAC_BITS);
    y30           = {y[FRAC_BITS:0], {SH{1'b0}}};
    rem30         = (Y30_W'(1) << INT_FRAC) - y30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else begin
      sb_r.valid <= sb_nxt.valid;
    end
    sb_r.action <= sb_nxt.action;
    sb_r.neg    <= sb_nxt.neg;
    sb_r.oor    <= sb_nxt.oor;
    y30_r       <= y30;
    n_r         <= ROOT_W'(rem30) << INT_FRAC;
  end

  icsa_horner u_horner (
    .clk     (clk),
    .y30_in  (y30_r),
    .acc_out (acc)
  );

  icsa_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .sb_in    (sb_r),
    .n_in     (n_r),
    .sb_out   (sb_root),
    .root_out (root)
  );

  icsa_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .sb_in     (sb_root),
    .acc_in    (acc),
    .root_in   (root),
    .valid_out (out_valid),
    .angle_out (angle),
    .oor_out   (out_out_of_range)
  );

  assign out_angle = $signed(angle);
  assign busy      = 1'b0;
endmodule

// ----- hdl/icsa_checker.sv -----
// ----------------------------------------------------------------------------
// icsa_checker
// Port-level checks on latency and result values of the top level.
// ----------------------------------------------------------------------------
module icsa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [icsa_pkg::ANGLE_W-1:0] out_angle,
  input logic                                out_out_of_range
);
  import icsa_pkg::*;

  logic [PIPE_LAT-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= {acc_r[PIPE_LAT-2:0], start & !busy};
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == acc_r[PIPE_LAT-1])
    else $error("result beat not at fixed latency");

  a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      (out_angle == '0 || out_angle == HALF_A[ANGLE_W-1:0]))
    else $error("out of range result not zero or half pi");

  a_max_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      !($signed(out_angle) > $signed(PI_A[ANGLE_W-1:0])))
    else $error("angle above pi");
endmodule

bind inverse_cosine_sine_approx icsa_checker u_icsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_angle        (out_angle),
  .out_out_of_range (out_out_of_range)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for inverse_cosine_sine_approx: directed and random arguments,
// random start gaps, results predicted bit for bit and checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import icsa_pkg::*;

  localparam longint COEF_Q30 [8] = '{
    64'sd1686629690, -64'sd230423709, 64'sd95540460, -64'sd53874249,
    64'sd33169905, -64'sd18348235, 64'sd7161955, -64'sd1355589
  };
  localparam longint PI_Q  = 64'sd3373259423;
  localparam longint HPI_Q = 64'sd1686629713;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic                      oor;
  } angle_beat_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint round_drop(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint m;
    longint p;
    m = a < 0 ? -a : a;
    p = (m * b + (64'sd1 <<< 29)) >>> 30;
    return a < 0 ? -p : p;
  endfunction

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 60;
    for (int k = 0; k < 31; k++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic angle_beat_t predict_angle(input icsa_act_t act,
                                                input logic signed [X_W-1:0] xv);
    angle_beat_t r;
    longint x, y, y30, acc, rt, prod, res;
    x = xv;
    y = x < 0 ? -x : x;
    r.oor = y > (64'sd1 <<< FRAC_BITS);
    if (r.oor) begin
      res = act == ACT_ASIN ? round_drop(HPI_Q, SH) : 0;
    end else begin
      y30 = y <<< SH;
      acc = COEF_Q30[7];
      for (int i = 6; i >= 0; i--) acc = q30_mul(acc, y30) + COEF_Q30[i];
      rt = isqrt(longint'((64'sd1 <<< 30) - y30) << 30);
      prod = round_drop(q30_mul(acc, rt), SH);
      if (act == ACT_ACOS) begin
        res = x < 0 ? round_drop(PI_Q, SH) - prod : prod;
      end else begin
        res = round_drop(HPI_Q, SH) - prod;
        if (x < 0) res = -res;
      end
    end
    r.angle = res[ANGLE_W-1:0];
    return r;
  endfunction

  class angle_scoreboard;
    angle_beat_t pending[$];
    int checked = 0;
    function void note_input(icsa_act_t act, logic signed [X_W-1:0] xv);
      pending.push_back(predict_angle(act, xv));
    endfunction
    task check_result(logic signed [ANGLE_W-1:0] ang, logic oor);
      angle_beat_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ang !== e.angle)
        report($sformatf("angle got %0d expected %0d", ang, e.angle));
      if (oor !== e.oor)
        report($sformatf("out_of_range got %0b expected %0b", oor, e.oor));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_action = 0;
  logic signed [X_W-1:0] in_x_value = '0;
  logic out_valid;
  logic signed [ANGLE_W-1:0] out_angle;
  logic out_out_of_range;
  int cycles = 0;
  angle_scoreboard sb = new();

  inverse_cosine_sine_approx i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_angle(out_angle),
    .out_out_of_range(out_out_of_range)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) sb.note_input(icsa_act_t'(in_action), in_x_value);
    if (rst_n && out_valid) sb.check_result(out_angle, out_out_of_range);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one beat, then a random gap; start stays high across back-to-back beats
  task automatic send_beat(input logic act, input logic signed [X_W-1:0] xv);
    int gap;
    in_action <= act;
    in_x_value <= xv;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = $urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 19) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 4));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic signed [X_W-1:0] rand_arg();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return X_W'($signed($urandom_range(0, 131072)) - 65536);
    if (k < 8) return X_W'($signed($urandom_range(0, 6)) - 3 + 65536);
    if (k < 9) return X_W'($signed($urandom_range(0, 6)) - 3 - 65536);
    return X_W'($urandom);
  endfunction

  initial begin
    logic signed [X_W-1:0] dir[$];
    dir = {18'sd0, 18'sd1, -18'sd1, 18'sd65536, -18'sd65536, 18'sd65537,
           -18'sd65537, 18'sd131071, 18'sh20000, 18'sd32768, -18'sd32768,
           18'sd65535, -18'sd65535};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir[i]) begin
      send_beat(ACT_ACOS, dir[i]);
      send_beat(ACT_ASIN, dir[i]);
    end
    for (int n = 0; n < 1350; n++) begin
      if (n == 600) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_beat(1'($urandom_range(0, 1)), rand_arg());
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    $display("covered %0d results, arccos and arcsin, in and beyond the unit range",
             sb.checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/icsa_pkg.sv
hdl/icsa_horner.sv
hdl/icsa_root.sv
hdl/icsa_final.sv
hdl/inverse_cosine_sine_approx.sv
hdl/icsa_checker.sv
tb/tb_top.sv
